@@ sv/nfg_pkg.sv @@
// Shared constants, types and sine table functions of the FSK tone generator.
package nfg_pkg;

  localparam int NUM_TONE_COUNT     = 8;
  localparam int SAMPLES_PER_SYMBOL = 64;
  localparam int SINE_ROM_DEPTH     = 256;
  localparam int MAX_OUT            = 64;
  localparam int TONE_W             = $clog2(NUM_TONE_COUNT);
  localparam int CNT_W              = 7;
  localparam int ROM_AW             = $clog2(SINE_ROM_DEPTH);
  localparam int Q_DEPTH            = 2;
  localparam int Q_AW               = $clog2(Q_DEPTH);
  localparam int Q_CW               = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
  localparam logic [15:0] AMP_RESET      = 16'd32768;
  localparam logic [31:0] BASE_INC_RESET = 32'd402653184;
  localparam logic [31:0] STEP_INC_RESET = 32'd67108864;

  localparam logic [1:0] CFG_AMPLITUDE = 2'd0;
  localparam logic [1:0] CFG_BASE_INC  = 2'd1;
  localparam logic [1:0] CFG_STEP_INC  = 2'd2;

  localparam logic OP_BURST = 1'b0;
  localparam logic OP_TONE  = 1'b1;

  typedef struct packed {
    logic [15:0] amplitude;
    logic [31:0] base_increment;
    logic [31:0] step_increment;
  } cfg_t;

  typedef struct packed {
    logic              burst;
    logic [TONE_W-1:0] tone;
    logic [CNT_W-1:0]  count;
    logic [31:0]       increment;
  } cmd_t;

  function automatic logic [14:0] quarter_wave(input logic [6:0] q);
    logic [14:0] v;
    case (q)
      7'd0: v = 15'd0;          7'd1: v = 15'd804;        7'd2: v = 15'd1608;
      7'd3: v = 15'd2410;       7'd4: v = 15'd3212;       7'd5: v = 15'd4011;
      7'd6: v = 15'd4808;       7'd7: v = 15'd5602;       7'd8: v = 15'd6393;
      7'd9: v = 15'd7179;       7'd10: v = 15'd7962;      7'd11: v = 15'd8739;
      7'd12: v = 15'd9512;      7'd13: v = 15'd10278;     7'd14: v = 15'd11039;
      7'd15: v = 15'd11793;     7'd16: v = 15'd12539;     7'd17: v = 15'd13279;
      7'd18: v = 15'd14010;     7'd19: v = 15'd14732;     7'd20: v = 15'd15446;
      7'd21: v = 15'd16151;     7'd22: v = 15'd16846;     7'd23: v = 15'd17530;
      7'd24: v = 15'd18204;     7'd25: v = 15'd18868;     7'd26: v = 15'd19519;
      7'd27: v = 15'd20159;     7'd28: v = 15'd20787;     7'd29: v = 15'd21403;
      7'd30: v = 15'd22005;     7'd31: v = 15'd22594;     7'd32: v = 15'd23170;
      7'd33: v = 15'd23731;     7'd34: v = 15'd24279;     7'd35: v = 15'd24811;
      7'd36: v = 15'd25329;     7'd37: v = 15'd25832;     7'd38: v = 15'd26319;
      7'd39: v = 15'd26790;     7'd40: v = 15'd27245;     7'd41: v = 15'd27683;
      7'd42: v = 15'd28105;     7'd43: v = 15'd28510;     7'd44: v = 15'd28898;
      7'd45: v = 15'd29268;     7'd46: v = 15'd29621;     7'd47: v = 15'd29956;
      7'd48: v = 15'd30273;     7'd49: v = 15'd30571;     7'd50: v = 15'd30852;
      7'd51: v = 15'd31113;     7'd52: v = 15'd31356;     7'd53: v = 15'd31580;
      7'd54: v = 15'd31785;     7'd55: v = 15'd31971;     7'd56: v = 15'd32137;
      7'd57: v = 15'd32285;     7'd58: v = 15'd32412;     7'd59: v = 15'd32521;
      7'd60: v = 15'd32609;     7'd61: v = 15'd32678;     7'd62: v = 15'd32728;
      7'd63: v = 15'd32757;     7'd64: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sine_rom(input logic [ROM_AW-1:0] idx);
    logic [5:0]  q;
    logic [1:0]  quad;
    logic [14:0] mag;
    q    = idx[5:0];
    quad = idx[7:6];
    if (quad[0]) begin
      mag = quarter_wave(7'd64 - {1'b0, q});
    end else begin
      mag = quarter_wave({1'b0, q});
    end
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage

@@ sv/nfg_front.sv @@
// Front end: accepts requests, clamps the tone, sizes the run and works out the increment.
module nfg_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [7:0]                   in_symbol,
  input  logic [6:0]                   in_sample_count,
  input  nfg_pkg::cfg_t                cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output nfg_pkg::cmd_t                q_cmd
);
  import nfg_pkg::*;

  logic [TONE_W-1:0] tone;
  logic [CNT_W-1:0]  count;
  logic [31:0]       step_prod;

  always_comb begin
    if (in_symbol >= 8'(NUM_TONE_COUNT)) begin
      tone = TONE_W'(NUM_TONE_COUNT - 1);
    end else begin
      tone = in_symbol[TONE_W-1:0];
    end
    if (in_operation == OP_BURST) begin
      count = CNT_W'(SAMPLES_PER_SYMBOL);
    end else if (in_sample_count > CNT_W'(MAX_OUT)) begin
      count = CNT_W'(MAX_OUT);
    end else begin
      count = in_sample_count;
    end
    step_prod = cfg.step_increment * {{(32-TONE_W){1'b0}}, tone};
  end

  assign in_ready = !q_full;

  // A tone request with no samples leaves the state alone, so it is dropped here.
  assign q_push = in_valid && !q_full && (count != '0);

  assign q_cmd.burst     = (in_operation == OP_BURST);
  assign q_cmd.tone      = tone;
  assign q_cmd.count     = count;
  assign q_cmd.increment = cfg.base_increment + step_prod;

endmodule

@@ sv/nfg_cmd_queue.sv @@
// Short command queue between the front end and the sample engine.
module nfg_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nfg_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output nfg_pkg::cmd_t head_cmd
);
  import nfg_pkg::*;

  cmd_t            store_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] fill_r, fill_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (fill_r == Q_CW'(Q_DEPTH));
  assign empty    = (fill_r == '0);
  assign head_cmd = store_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/nfg_back.sv @@
// Sample engine: per-tone phase accumulators, sine lookup, interpolation, gain and saturation.
module nfg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        amplitude,
  input  logic               q_empty,
  input  nfg_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_last_sample
);
  import nfg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         tone_phase_r [NUM_TONE_COUNT];
  logic [31:0]         phase_r, phase_nxt;
  logic [31:0]         inc_r;
  logic [TONE_W-1:0]   tone_r;
  logic [CNT_W-1:0]    remaining_r, remaining_nxt;

  logic                en;
  logic                issue;
  logic                issue_last;

  logic                v1_r, v2_r, v3_r, vo_r;
  logic                l1_r, l2_r, l3_r, lo_r;
  logic signed [15:0]  s0_r, s1_r;
  logic [15:0]         f_r;
  logic signed [33:0]  v_r;
  logic signed [50:0]  p_r;
  logic signed [15:0]  sample_r;

  logic [ROM_AW-1:0]   rom_idx;
  logic signed [17:0]  w0;
  logic signed [17:0]  w1;
  logic signed [33:0]  v_nxt;
  logic signed [50:0]  p_nxt;
  logic signed [50:0]  p_adj;
  logic signed [19:0]  q_val;
  logic signed [15:0]  sample_nxt;

  assign en         = !vo_r || out_ready;
  assign issue      = en && (state_r == ST_RUN);
  assign issue_last = issue && (remaining_r == CNT_W'(1));
  assign q_pop      = en && (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt     = ST_RUN;
          remaining_nxt = q_head.count;
          phase_nxt     = q_head.burst ? QUARTER_TURN : tone_phase_r[q_head.tone];
        end
      end
      ST_RUN: begin
        if (issue) begin
          phase_nxt     = phase_r + inc_r;
          remaining_nxt = remaining_r - 1'b1;
          if (issue_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vo_r        <= 1'b0;
      for (int t = 0; t < NUM_TONE_COUNT; t++) begin
        tone_phase_r[t] <= QUARTER_TURN;
      end
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      if (en) begin
        v1_r <= issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
        vo_r <= v3_r;
      end
      if (issue) begin
        tone_phase_r[tone_r] <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    if (q_pop) begin
      inc_r  <= q_head.increment;
      tone_r <= q_head.tone;
    end
  end

  always_comb begin
    rom_idx    = phase_r[31:24];
    w1         = $signed({2'b00, f_r});
    w0         = 18'sd65536 - w1;
    v_nxt      = s0_r * w0 + s1_r * w1;
    p_nxt      = v_r * $signed({1'b0, amplitude});
    p_adj      = p_r[50] ? p_r + 51'sd2147483647 : p_r;
    q_val      = 20'(p_adj >>> 31);
    if (q_val > 20'sd32767) begin
      sample_nxt = 16'sd32767;
    end else if (q_val < -20'sd32768) begin
      sample_nxt = -16'sd32768;
    end else begin
      sample_nxt = q_val[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r     <= sine_rom(rom_idx);
      s1_r     <= sine_rom(rom_idx + 1'b1);
      f_r      <= phase_r[23:8];
      l1_r     <= issue_last;
      v_r      <= v_nxt;
      l2_r     <= l1_r;
      p_r      <= p_nxt;
      l3_r     <= l2_r;
      sample_r <= sample_nxt;
      lo_r     <= l3_r;
    end
  end

  assign out_valid       = vo_r;
  assign out_sample      = sample_r;
  assign out_last_sample = lo_r;

endmodule

@@ sv/nco_fsk_tone_generator.sv @@
// Top level of the 8-FSK tone generator: configuration registers, front end, queue and engine.
// The first sample of a request is presented after the queue, the engine's tone phase load
// and its lookup, interpolation, gain and saturation registers. Throughput: one sample per
// cycle while out_ready holds; the engine loads the tone phase in its idle state before a run.
// Requests are queued two deep, so the next one is taken while the current run plays out.
// Reset (synchronous, active low) returns every tone phase to a quarter turn and the
// registers to amplitude 1.0 and the default base and step increments.
module nco_fsk_tone_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_symbol,
  input  logic [6:0]         in_sample_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_last_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import nfg_pkg::*;

  cfg_t cfg_r;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude      <= AMP_RESET;
      cfg_r.base_increment <= BASE_INC_RESET;
      cfg_r.step_increment <= STEP_INC_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AMPLITUDE: cfg_r.amplitude      <= cfg_data[15:0];
        CFG_BASE_INC:  cfg_r.base_increment <= cfg_data;
        CFG_STEP_INC:  cfg_r.step_increment <= cfg_data;
        default: ;
      endcase
    end
  end

  nfg_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_symbol       (in_symbol),
    .in_sample_count (in_sample_count),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  nfg_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  nfg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .amplitude       (cfg_r.amplitude),
    .q_empty         (q_empty),
    .q_head          (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last_sample (out_last_sample)
  );

endmodule
